@@ sv/latg_pkg.sv @@
// ----------------------------------------------------------------------------
// latg_pkg
// Shared types and constants for the toroidal Life grid core: request codes,
// controller states, counter widths and the per-row cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package latg_pkg;

  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  localparam int REQ_W   = 2;
  localparam int COORD_W = 8;
  localparam int LIVE_W  = 13;
  localparam int GEN_W   = 16;
  localparam int GROUP_W = 8;

  localparam int              LIVE_MAX = 8191;
  localparam logic [GEN_W-1:0] GEN_MAX = 16'hFFFF;

  localparam logic [3:0] NB_SURVIVE = 4'd2;
  localparam logic [3:0] NB_BIRTH   = 4'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_TOGGLE = 2'd0,
    REQ_STEP   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } latg_req_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_TOGGLE = 3'd1,
    ST_STEP   = 3'd2,
    ST_TALLY  = 3'd3,
    ST_CLEAR  = 3'd4,
    ST_REPORT = 3'd5
  } latg_state_e;

  typedef struct packed {
    logic shift;
    logic clear;
    logic toggle;
  } latg_cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/latg_row_cell.sv @@
// ----------------------------------------------------------------------------
// latg_row_cell
// One grid row. Shifts in the row behind it during a generation, clears to
// zero and flips a single cell when its row is addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module latg_row_cell import latg_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int ROW_IDX   = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire latg_cell_ctrl_t      ctrl_i,
  input  wire logic [COORD_W-1:0]   tog_row_i,
  input  wire logic [GRID_COLS-1:0] tog_mask_i,
  input  wire logic [GRID_COLS-1:0] shift_in_i,
  output logic      [GRID_COLS-1:0] row_o,
  output logic                      hit_o
);

  logic [GRID_COLS-1:0] row_q, row_d;
  logic                 match;

  assign match = (32'(tog_row_i) == 32'(ROW_IDX));
  assign hit_o = match && (|(row_q & tog_mask_i));
  assign row_o = row_q;

  always_comb begin
    priority if (ctrl_i.clear) begin
      row_d = '0;
    end else if (ctrl_i.shift) begin
      row_d = shift_in_i;
    end else if (ctrl_i.toggle && match) begin
      row_d = row_q ^ tog_mask_i;
    end else begin
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/latg_rule.sv @@
// ----------------------------------------------------------------------------
// latg_rule
// B3/S23 next-row logic: counts the eight wrap-around neighbours of every
// column from the rows above, at and below, and applies the Life rule.
// ----------------------------------------------------------------------------
`default_nettype none

module latg_rule import latg_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  wire logic [GRID_COLS-1:0] up_i,
  input  wire logic [GRID_COLS-1:0] cur_i,
  input  wire logic [GRID_COLS-1:0] dn_i,
  output logic      [GRID_COLS-1:0] nxt_o
);

  for (genvar j = 0; j < GRID_COLS; j++) begin : g_col
    localparam int JL = (j + GRID_COLS - 1) % GRID_COLS;
    localparam int JR = (j + 1) % GRID_COLS;
    logic [3:0] nb;

    assign nb = 4'(up_i[JL]) + 4'(up_i[j]) + 4'(up_i[JR])
              + 4'(cur_i[JL]) + 4'(cur_i[JR])
              + 4'(dn_i[JL]) + 4'(dn_i[j]) + 4'(dn_i[JR]);
    assign nxt_o[j] = cur_i[j] ? ((nb == NB_SURVIVE) || (nb == NB_BIRTH))
                               : (nb == NB_BIRTH);
  end

endmodule

`default_nettype wire

@@ sv/life_automaton_torus_grid_core.sv @@
// ----------------------------------------------------------------------------
// life_automaton_torus_grid_core
// Toroidal Conway Life grid (B3/S23) held in a ring of row cells. Requests
// toggle one cell, step one generation or clear the grid; each request
// returns the live count and the saturating generation counter.
//
//   channel   signals                                       transfer
//   request   start, busy, req_type_i, cell_row_i,          start && !busy
//             cell_col_i
//   result    result_valid_o, live_count_o,                 result_valid_o
//             generation_count_o, toggle_ignored_o
//
// Step: the row ring rotates once through the rule unit, plus a two-stage
// popcount. Toggle and clear pass through their own state before the
// report state; the unused code goes straight to the report state.
// A new request may be taken in the cycle the result strobe is shown.
// Reset kills every cell and zeroes both counters at once.
// The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module life_automaton_torus_grid_core import latg_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [REQ_W-1:0]   req_type_i,
  input  wire logic [COORD_W-1:0] cell_row_i,
  input  wire logic [COORD_W-1:0] cell_col_i,
  output logic                    result_valid_o,
  output logic [LIVE_W-1:0]       live_count_o,
  output logic [GEN_W-1:0]        generation_count_o,
  output logic                    toggle_ignored_o
);

  localparam int LW    = $clog2(GRID_ROWS * GRID_COLS + 1);
  localparam int SW    = $clog2(GRID_COLS + 1);
  localparam int NG    = (GRID_COLS + GROUP_W - 1) / GROUP_W;
  localparam int GCW   = $clog2(GROUP_W + 1);
  localparam int CNT_W = $clog2(GRID_ROWS + 2);

  latg_state_e          state_q, state_d;
  latg_cell_ctrl_t      ctrl;
  logic                 accept;
  logic                 in_range;
  logic                 old_bit;
  logic                 last_row;

  logic [COORD_W-1:0]   row_q, row_d;
  logic [COORD_W-1:0]   col_q, col_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [GRID_COLS-1:0] prev_q, prev_d;
  logic [GRID_COLS-1:0] first_q, first_d;
  logic [LW-1:0]        acc_q, acc_d;
  logic [LW-1:0]        live_q, live_d;
  logic [GEN_W-1:0]     gen_q, gen_d;
  logic                 ign_q, ign_d;
  logic                 shift_q;
  logic                 grp_v_q;
  logic [GCW-1:0]       grp_q [NG];
  logic [GCW-1:0]       grp_d [NG];
  logic [SW-1:0]        grp_sum;
  logic [NG*GROUP_W-1:0] tail_pad;

  logic                 res_valid_q, res_valid_d;
  logic [LIVE_W-1:0]    res_live_q, res_live_d;
  logic [GEN_W-1:0]     res_gen_q, res_gen_d;
  logic                 res_ign_q, res_ign_d;

  logic [GRID_COLS-1:0] row_w [GRID_ROWS];
  logic [GRID_ROWS-1:0] hit_w;
  logic [GRID_COLS-1:0] tog_mask;
  logic [GRID_COLS-1:0] nxt_row;
  logic [GRID_COLS-1:0] dn_row;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(row_q) < 32'(GRID_ROWS)) && (32'(col_q) < 32'(GRID_COLS));
  assign old_bit  = |hit_w;
  assign last_row = (cnt_q == CNT_W'(GRID_ROWS - 1));
  assign dn_row   = last_row ? first_q : row_w[1];

  for (genvar j = 0; j < GRID_COLS; j++) begin : g_mask
    assign tog_mask[j] = (32'(col_q) == 32'(j));
  end

  // row ring: each row takes the one behind it, the tail takes the new row
  for (genvar k = 0; k < GRID_ROWS; k++) begin : g_row
    logic [GRID_COLS-1:0] shift_in;
    if (k == GRID_ROWS - 1) begin : g_tail
      assign shift_in = nxt_row;
    end else begin : g_body
      assign shift_in = row_w[k+1];
    end

    latg_row_cell #(
      .GRID_COLS (GRID_COLS),
      .ROW_IDX   (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .tog_row_i  (row_q),
      .tog_mask_i (tog_mask),
      .shift_in_i (shift_in),
      .row_o      (row_w[k]),
      .hit_o      (hit_w[k])
    );
  end

  latg_rule #(
    .GRID_COLS (GRID_COLS)
  ) u_rule (
    .up_i  (prev_q),
    .cur_i (row_w[0]),
    .dn_i  (dn_row),
    .nxt_o (nxt_row)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (latg_req_e'(req_type_i))
            REQ_TOGGLE: state_d = ST_TOGGLE;
            REQ_STEP:   state_d = ST_STEP;
            REQ_CLEAR:  state_d = ST_CLEAR;
            REQ_NONE:   state_d = ST_REPORT;
          endcase
        end
      end
      ST_STEP: begin
        if (cnt_q == CNT_W'(GRID_ROWS + 1)) begin
          state_d = ST_TALLY;
        end
      end
      ST_TALLY:  state_d = ST_REPORT;
      ST_TOGGLE: state_d = ST_REPORT;
      ST_CLEAR:  state_d = ST_REPORT;
      ST_REPORT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // cell control
  always_comb begin
    ctrl.shift  = (state_q == ST_STEP) && (32'(cnt_q) < 32'(GRID_ROWS));
    ctrl.clear  = (state_q == ST_CLEAR);
    ctrl.toggle = (state_q == ST_TOGGLE) && in_range;
  end

  // group popcount of the newest row, then sum of groups
  assign tail_pad = (NG*GROUP_W)'(row_w[GRID_ROWS-1]);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int b = 0; b < GROUP_W; b++) begin
        grp_d[g] = grp_d[g] + GCW'(tail_pad[g*GROUP_W + b]);
      end
    end
  end

  always_comb begin
    grp_sum = '0;
    for (int g = 0; g < NG; g++) begin
      grp_sum = grp_sum + SW'(grp_q[g]);
    end
  end

  // datapath
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    first_d = first_q;
    acc_d   = acc_q;
    live_d  = live_q;
    gen_d   = gen_q;
    ign_d   = ign_q;

    if (accept) begin
      row_d   = cell_row_i;
      col_d   = cell_col_i;
      cnt_d   = '0;
      prev_d  = row_w[GRID_ROWS-1];
      first_d = row_w[0];
      acc_d   = '0;
      ign_d   = 1'b0;
    end else begin
      if (state_q == ST_STEP) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (ctrl.shift) begin
        prev_d = row_w[0];
      end
      if (grp_v_q) begin
        acc_d = acc_q + LW'(grp_sum);
      end
    end

    unique case (state_q)
      ST_TOGGLE: begin
        ign_d = !in_range;
        if (in_range) begin
          if (!old_bit) begin
            live_d = live_q + LW'(1);
          end else if (live_q != '0) begin
            live_d = live_q - LW'(1);
          end
        end
      end
      ST_TALLY: begin
        live_d = acc_q;
        if (gen_q != GEN_MAX) begin
          gen_d = gen_q + GEN_W'(1);
        end
      end
      ST_CLEAR: begin
        live_d = '0;
        gen_d  = '0;
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    res_valid_d = (state_q == ST_REPORT);
    res_live_d  = res_live_q;
    res_gen_d   = res_gen_q;
    res_ign_d   = res_ign_q;
    if (state_q == ST_REPORT) begin
      res_live_d = (32'(live_q) > 32'(LIVE_MAX)) ? LIVE_W'(LIVE_MAX) : LIVE_W'(live_q);
      res_gen_d  = gen_q;
      res_ign_d  = ign_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      live_q      <= '0;
      gen_q       <= '0;
      ign_q       <= 1'b0;
      shift_q     <= 1'b0;
      grp_v_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      live_q      <= live_d;
      gen_q       <= gen_d;
      ign_q       <= ign_d;
      shift_q     <= ctrl.shift;
      grp_v_q     <= shift_q;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    col_q     <= col_d;
    prev_q    <= prev_d;
    first_q   <= first_d;
    acc_q     <= acc_d;
    grp_q     <= grp_d;
    res_live_q <= res_live_d;
    res_gen_q  <= res_gen_d;
    res_ign_q  <= res_ign_d;
  end

  assign result_valid_o     = res_valid_q;
  assign live_count_o       = res_live_q;
  assign generation_count_o = res_gen_q;
  assign toggle_ignored_o   = res_ign_q;

endmodule

`default_nettype wire

@@ sv/latg_checker.sv @@
// ----------------------------------------------------------------------------
// latg_checker
// Port-level checks on the Life grid core: request and result sequencing
// and the fixed latency and values of a clear.
// ----------------------------------------------------------------------------
`default_nettype none

module latg_checker import latg_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [REQ_W-1:0]   req_type_i,
  input wire logic               result_valid_o,
  input wire logic [LIVE_W-1:0]  live_count_o,
  input wire logic [GEN_W-1:0]   generation_count_o
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  a_busy_only_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a request");

  a_result_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == REQ_CLEAR)) |->
      ##3 (result_valid_o && (live_count_o == '0) && (generation_count_o == '0)))
    else $error("clear did not report an empty grid");

endmodule

bind life_automaton_torus_grid_core latg_checker u_latg_checker (.*);

`default_nettype wire
